// ===== rtl/tiac_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet IAC filter package
// Shared types and protocol constants for the Telnet receive filter.
// ----------------------------------------------------------------------------
package tiac_pkg;

	localparam int unsigned OPT_COUNT  = 256;
	localparam int unsigned OPT_AW     = 8;
	localparam int unsigned CFG_IDX_W  = 2;

	// Telnet command codes
	localparam logic [7:0] TN_IAC  = 8'hFF;
	localparam logic [7:0] TN_DONT = 8'hFE;
	localparam logic [7:0] TN_DO   = 8'hFD;
	localparam logic [7:0] TN_WONT = 8'hFC;
	localparam logic [7:0] TN_WILL = 8'hFB;
	localparam logic [7:0] TN_SB   = 8'hFA;
	localparam logic [7:0] TN_SE   = 8'hF0;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_NUL  = 8'h00;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OPT_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPT_SECOND = 2'd1;

	// Output channel codes
	localparam logic CHAN_DATA  = 1'b0;
	localparam logic CHAN_REPLY = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       session_restart;
	} in_item_t;

	typedef struct packed {
		logic       channel;
		logic [7:0] value;
		logic       last;
	} out_item_t;

endpackage

// ===== rtl/telnet_iac_input_filter.sv =====
// An accepted byte passes stage 1 and then the output register before its result shows.
// Throughput: one byte per cycle while the input is not stalled; a negotiation reply
// occupies the output for its three bytes, and the input stalls once stage 1 is also full.
// Reset: parser returns to the data phase, then a clearing pass over all 256 entries
// of the answered-option memory runs with the input stalled. A session restart
// starts the same pass. Configuration returns to options 1 and 3.
// ----------------------------------------------------------------------------
// Telnet IAC input filter
// Strips Telnet command sequences from a received byte stream and produces
// option-negotiation replies, each option being answered at most once.
// ----------------------------------------------------------------------------
module telnet_iac_input_filter
	import tiac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam logic [2:0] PH_DATA   = 3'd0;
	localparam logic [2:0] PH_IAC    = 3'd1;
	localparam logic [2:0] PH_OPT    = 3'd2;
	localparam logic [2:0] PH_SB     = 3'd3;
	localparam logic [2:0] PH_SB_IAC = 3'd4;
	localparam logic [2:0] PH_CR     = 3'd5;

	localparam logic [1:0] IDX_IAC  = 2'd0;
	localparam logic [1:0] IDX_VERB = 2'd1;
	localparam logic [1:0] IDX_OPT  = 2'd2;

	// Configuration
	logic [7:0] opt_first_q;
	logic [7:0] opt_second_q;

	// Parser state
	logic [2:0] phase_q;
	logic [7:0] verb_q;

	// Clearing pass
	logic              clr_active_q;
	logic [OPT_AW-1:0] clr_addr_q;

	// Stage 1: classified item waiting for the memory lookup
	logic       valid_s1;
	logic       reply_s1;
	logic [7:0] byte_s1;
	logic [7:0] opt_s1;

	// Output register
	logic       out_valid_q;
	logic       out_reply_q;
	logic [1:0] out_idx_q;
	logic [7:0] out_byte_q;
	logic [7:0] out_opt_q;

	logic       accept;
	logic       out_take;
	logic       out_last;
	logic       out_free;
	logic       adv_s1;
	logic       emit_s1;
	logic       answered;

	logic [2:0] phase_d;
	logic [7:0] verb_d;
	logic       produce;
	logic       reply_d;
	logic [7:0] byte_d;

	logic              ram_we;
	logic [OPT_AW-1:0] ram_waddr;
	logic              ram_wdata;

	assign cfg_ready = 1'b1;

	assign out_take = out_valid_q && !out_stall;
	assign out_last = !out_reply_q || (out_idx_q == IDX_OPT);
	assign out_free = !out_valid_q || (out_take && out_last);
	assign adv_s1   = valid_s1 && out_free;
	assign emit_s1  = !reply_s1 || !answered;
	assign in_stall = clr_active_q || (valid_s1 && !out_free);
	assign accept   = in_valid && !in_stall;

	// An option byte is at least three transactions behind the previous one,
	// so the write-back of stage 1 always lands before the next lookup.
	assign ram_we    = clr_active_q || (adv_s1 && reply_s1 && !answered);
	assign ram_waddr = clr_active_q ? clr_addr_q : opt_s1;
	assign ram_wdata = !clr_active_q;

	tiac_ram #(
		.WIDTH (1),
		.DEPTH (OPT_COUNT)
	) u_answered_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_data.rx_byte),
		.rdata (answered)
	);

	// Parser next state and classification of the accepted byte
	always_comb begin
		phase_d = phase_q;
		verb_d  = verb_q;
		produce = 1'b0;
		reply_d = 1'b0;
		byte_d  = in_data.rx_byte;
		case (phase_q)
			PH_DATA: begin
				if (in_data.rx_byte == TN_IAC) begin
					phase_d = PH_IAC;
				end else begin
					produce = 1'b1;
					if (in_data.rx_byte == CH_CR) begin
						phase_d = PH_CR;
					end
				end
			end
			PH_CR: begin
				if (in_data.rx_byte == CH_NUL) begin
					phase_d = PH_DATA;
				end else if (in_data.rx_byte == TN_IAC) begin
					phase_d = PH_IAC;
				end else begin
					produce = 1'b1;
					if (in_data.rx_byte != CH_CR) begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_IAC: begin
				if (in_data.rx_byte == TN_IAC) begin
					produce = 1'b1;
					phase_d = PH_DATA;
				end else if (in_data.rx_byte == TN_WILL || in_data.rx_byte == TN_WONT ||
						in_data.rx_byte == TN_DO || in_data.rx_byte == TN_DONT) begin
					verb_d  = in_data.rx_byte;
					phase_d = PH_OPT;
				end else if (in_data.rx_byte == TN_SB) begin
					phase_d = PH_SB;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_OPT: begin
				if (verb_q == TN_WILL) begin
					produce = 1'b1;
					reply_d = 1'b1;
					byte_d  = (in_data.rx_byte == opt_first_q ||
						in_data.rx_byte == opt_second_q) ? TN_DO : TN_DONT;
				end else if (verb_q == TN_DO) begin
					produce = 1'b1;
					reply_d = 1'b1;
					byte_d  = TN_WONT;
				end
				phase_d = PH_DATA;
			end
			PH_SB: begin
				if (in_data.rx_byte == TN_IAC) begin
					phase_d = PH_SB_IAC;
				end
			end
			PH_SB_IAC: begin
				phase_d = (in_data.rx_byte == TN_SE) ? PH_DATA : PH_SB;
			end
			default: begin
				phase_d = PH_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_first_q  <= 8'd1;
			opt_second_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OPT_FIRST:  opt_first_q  <= cfg_data;
				CFG_OPT_SECOND: opt_second_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DATA;
			verb_q       <= 8'd0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == OPT_AW'(OPT_COUNT - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
			if (accept) begin
				if (in_data.session_restart) begin
					phase_q      <= PH_DATA;
					verb_q       <= 8'd0;
					clr_active_q <= 1'b1;
					clr_addr_q   <= '0;
				end else begin
					phase_q <= phase_d;
					verb_q  <= verb_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && !in_data.session_restart && produce) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_s1 <= reply_d;
			byte_s1  <= byte_d;
			opt_s1   <= in_data.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= IDX_IAC;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= IDX_IAC;
		end else if (out_take && out_last) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_idx_q <= out_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			out_reply_q <= reply_s1;
			out_byte_q  <= byte_s1;
			out_opt_q   <= opt_s1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.channel = out_reply_q ? CHAN_REPLY : CHAN_DATA;
		out_data.last    = out_last;
		if (!out_reply_q) begin
			out_data.value = out_byte_q;
		end else begin
			case (out_idx_q)
				IDX_IAC:  out_data.value = TN_IAC;
				IDX_VERB: out_data.value = out_byte_q;
				IDX_OPT:  out_data.value = out_opt_q;
				default:  out_data.value = out_opt_q;
			endcase
		end
	end

endmodule

// ===== rtl/tiac_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module tiac_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tiac_checker.sv =====
// ----------------------------------------------------------------------------
// Telnet IAC filter checker
// Port-level assertions for the Telnet receive filter, bound to the top level.
// ----------------------------------------------------------------------------
module tiac_checker
	import tiac_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A stalled result must be held until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Data bytes are always single-result transactions.
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.channel == CHAN_DATA |-> out_data.last)
		else $error("data byte not marked last");

	// The bytes of a reply follow each other without a gap.
	a_reply_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.channel == CHAN_REPLY && !out_data.last
		|=> out_valid && out_data.channel == CHAN_REPLY)
		else $error("reply interrupted");

	// A reply that directly follows a completed transaction opens with IAC.
	a_reply_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last
		|=> !(out_valid && out_data.channel == CHAN_REPLY) || out_data.value == TN_IAC)
		else $error("reply does not start with IAC");

	// The answered-option memory is being cleared just after reset.
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input taken during clearing pass");

endmodule

bind telnet_iac_input_filter tiac_checker u_tiac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== verif/telnet_iac_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telnet IAC filter checker
// Watches the input, output and configuration channels of the filter. It keeps
// its own model of the parser, the answered-option map and the option
// registers, and compares every output transaction against the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module telnet_iac_checker
	import tiac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatch_count,
	output int                   awaited_count
);

	typedef enum logic [2:0] {
		PH_DATA   = 3'd0,
		PH_IAC    = 3'd1,
		PH_OPT    = 3'd2,
		PH_SB     = 3'd3,
		PH_SB_IAC = 3'd4,
		PH_CR     = 3'd5
	} parse_phase_t;

	parse_phase_t phase;
	logic [7:0]   verb;
	logic [255:0] answered;
	logic [7:0]   opt_first;
	logic [7:0]   opt_second;
	out_item_t    due_bytes[$];

	task automatic clear_session();
		phase    = PH_DATA;
		verb     = 8'h00;
		answered = '0;
	endtask

	task automatic push_data(input logic [7:0] v);
		out_item_t r;
		r.channel = CHAN_DATA;
		r.value   = v;
		r.last    = 1'b1;
		due_bytes.push_back(r);
	endtask

	// An option is answered only once until the session is cleared.
	task automatic push_reply(input logic [7:0] reply_verb, input logic [7:0] opt);
		out_item_t r;
		if (!answered[opt]) begin
			answered[opt] = 1'b1;
			r.channel = CHAN_REPLY;
			r.last    = 1'b0;
			r.value   = TN_IAC;
			due_bytes.push_back(r);
			r.value   = reply_verb;
			due_bytes.push_back(r);
			r.value   = opt;
			r.last    = 1'b1;
			due_bytes.push_back(r);
		end
	endtask

	task automatic filter_byte(input in_item_t item);
		logic [7:0] b;
		b = item.rx_byte;
		if (item.session_restart) begin
			clear_session();
		end else begin
			case (phase)
				PH_DATA: begin
					if (b == TN_IAC) begin
						phase = PH_IAC;
					end else begin
						push_data(b);
						if (b == CH_CR)
							phase = PH_CR;
					end
				end
				PH_CR: begin
					if (b == CH_NUL) begin
						phase = PH_DATA;
					end else if (b == TN_IAC) begin
						phase = PH_IAC;
					end else begin
						push_data(b);
						if (b != CH_CR)
							phase = PH_DATA;
					end
				end
				PH_IAC: begin
					if (b == TN_IAC) begin
						push_data(TN_IAC);
						phase = PH_DATA;
					end else if (b == TN_WILL || b == TN_WONT || b == TN_DO || b == TN_DONT) begin
						verb  = b;
						phase = PH_OPT;
					end else if (b == TN_SB) begin
						phase = PH_SB;
					end else begin
						phase = PH_DATA;
					end
				end
				PH_OPT: begin
					if (verb == TN_WILL)
						push_reply((b == opt_first || b == opt_second) ? TN_DO : TN_DONT, b);
					else if (verb == TN_DO)
						push_reply(TN_WONT, b);
					phase = PH_DATA;
				end
				PH_SB: begin
					if (b == TN_IAC)
						phase = PH_SB_IAC;
				end
				PH_SB_IAC: begin
					phase = (b == TN_SE) ? PH_DATA : PH_SB;
				end
				default: begin
					phase = PH_DATA;
				end
			endcase
		end
	endtask

	task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected ch=%0d val=%02h last=%0d, got ch=%0d val=%02h last=%0d",
				$realtime, what, want.channel, want.value, want.last,
				got.channel, got.value, got.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			clear_session();
			opt_first  = 8'd1;
			opt_second = 8'd3;
			due_bytes.delete();
			mismatch_count = 0;
			awaited_count  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OPT_FIRST:  opt_first  = cfg_data;
					CFG_OPT_SECOND: opt_second = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				filter_byte(in_data);
			if (out_valid && !out_stall) begin
				if (due_bytes.size() == 0) begin
					want = '0;
					flag_mismatch("output transaction with nothing predicted", want, out_data);
				end else begin
					want = due_bytes.pop_front();
					if (out_data.channel !== want.channel || out_data.value !== want.value ||
						out_data.last !== want.last)
						flag_mismatch("output byte differs", want, out_data);
				end
			end
			awaited_count = due_bytes.size();
		end
	end

endmodule

// ===== verif/tb_telnet_iac_input_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telnet IAC input filter testbench
// Feeds the filter a directed run of Telnet sequences and then random streams
// of well-formed commands, subnegotiations, data and session restarts under
// three option settings and three patterns of back-pressure. The checker
// beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module tb_telnet_iac_input_filter;
	import tiac_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
	localparam logic [7:0]           TN_NOP          = 8'hF1;
	localparam int                   SETTLE_CYCLES   = 8;
	localparam int                   ITEMS_PER_PHASE = 95;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	int                   mismatch_count;
	int                   awaited_count;

	int         send_idle_pct;
	int         recv_idle_pct;
	int         items_sent;
	logic [7:0] opt_first;
	logic [7:0] opt_second;

	telnet_iac_input_filter dut (.*);
	telnet_iac_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic restart);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid                = 1'b1;
		in_data.rx_byte         = b;
		in_data.session_restart = restart;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_OPT_FIRST)
			opt_first = val;
		else if (idx == CFG_OPT_SECOND)
			opt_second = val;
	endtask

	// Wait for every predicted byte, then give the pipeline time to drain
	// anything that produces no output, such as a trailing restart.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Options are drawn mostly from a small pool so that repeats are common.
	function automatic logic [7:0] pick_option();
		case ($urandom_range(0, 3))
			0: return opt_first;
			1: return opt_second;
			2: return 8'($urandom_range(0, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_sequence();
		int         kind;
		int         n;
		logic [7:0] verb;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind < 45) begin
			send_item(CH_CR, 1'b0);
			case ($urandom_range(0, 3))
				0: send_item(CH_NUL, 1'b0);
				1: send_item(CH_CR, 1'b0);
				2: send_item(8'($urandom_range(0, 255)), 1'b0);
				default: begin
					send_item(TN_IAC, 1'b0);
					send_item(TN_IAC, 1'b0);
				end
			endcase
		end else if (kind < 53) begin
			send_item(TN_IAC, 1'b0);
			send_item(TN_IAC, 1'b0);
		end else if (kind < 87) begin
			if (kind < 71)
				verb = TN_WILL;
			else if (kind < 81)
				verb = TN_DO;
			else
				verb = $urandom_range(0, 1) ? TN_WONT : TN_DONT;
			send_item(TN_IAC, 1'b0);
			send_item(verb, 1'b0);
			send_item(pick_option(), 1'b0);
		end else if (kind < 93) begin
			send_item(TN_IAC, 1'b0);
			send_item(TN_SB, 1'b0);
			n = $urandom_range(0, 4);
			repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
			if ($urandom_range(0, 1)) begin
				send_item(TN_IAC, 1'b0);
				send_item(8'($urandom_range(0, 8'hEF)), 1'b0);
			end
			send_item(TN_IAC, 1'b0);
			send_item(TN_SE, 1'b0);
		end else if (kind < 97) begin
			send_item(TN_IAC, 1'b0);
			send_item(8'($urandom_range(8'hF0, 8'hF9)), 1'b0);
		end else if (kind < 98) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		int stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at       = items_sent + ITEMS_PER_PHASE;
		while (items_sent < stop_at)
			send_sequence();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_OPT_FIRST;
		cfg_data      = 8'h00;
		send_idle_pct = 25;
		recv_idle_pct = 66;
		items_sent    = 0;
		opt_first     = 8'd1;
		opt_second    = 8'd3;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sequences under the reset option settings.
		send_item(8'h00, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_NUL, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_WILL, 1'b0);
		send_item(8'd1, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_WILL, 1'b0);
		send_item(8'd1, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_DO, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_DONT, 1'b0);
		send_item(8'd6, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_SB, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_SE, 1'b0);
		send_item(TN_IAC, 1'b0);
		send_item(TN_NOP, 1'b0);
		send_item(8'h7E, 1'b1);
		settle();

		write_reg(CFG_OPT_FIRST, 8'h00);
		write_reg(CFG_OPT_SECOND, 8'hFF);
		run_phase(25, 66);
		settle();

		write_reg(CFG_OPT_FIRST, 8'd200);
		write_reg(CFG_OPT_SECOND, 8'd200);
		write_reg(CFG_IDX_SPARE_A, 8'h55);
		write_reg(CFG_IDX_SPARE_B, 8'hAA);
		run_phase(66, 25);
		settle();

		write_reg(CFG_OPT_FIRST, 8'($urandom_range(0, 255)));
		write_reg(CFG_OPT_SECOND, 8'($urandom_range(0, 255)));
		run_phase(0, 0);
		settle();

		if (mismatch_count == 0 && awaited_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== telnet_iac_input_filter.f =====
rtl/tiac_pkg.sv
rtl/tiac_ram.sv
rtl/telnet_iac_input_filter.sv
rtl/tiac_checker.sv
verif/telnet_iac_checker.sv
verif/tb_telnet_iac_input_filter.sv
